@@ rtl/core/arp_cache_with_request_retry_unit_macros.svh @@
// ----------------------------------------------------------------------------
// arp_cache_with_request_retry_unit_macros
// Assertion macros used by the block's top module.
// ----------------------------------------------------------------------------
`ifndef ARP_CACHE_WITH_REQUEST_RETRY_UNIT_MACROS_SVH
`define ARP_CACHE_WITH_REQUEST_RETRY_UNIT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ARPC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define ARPC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/arpc_pkg.sv @@
// ----------------------------------------------------------------------------
// arpc_pkg
// Types, codes and defaults shared by the ARP cache modules.
// ----------------------------------------------------------------------------
package arpc_pkg;

  localparam int unsigned CacheEntriesDef = 16;
  localparam int unsigned RequestSlotsDef = 8;

  localparam logic [15:0] EntryTimeoutRst = 16'd15;
  localparam logic [7:0]  RetryLimitRst   = 8'd5;
  localparam logic [15:0] RetryInterval   = 16'd1;

  localparam logic [1:0] ActTick   = 2'd0;
  localparam logic [1:0] ActLookup = 2'd1;
  localparam logic [1:0] ActInsert = 2'd2;
  localparam logic [1:0] ActQueue  = 2'd3;

  localparam logic [3:0] EvHit      = 4'd0;
  localparam logic [3:0] EvMiss     = 4'd1;
  localparam logic [3:0] EvInserted = 4'd2;
  localparam logic [3:0] EvDropped  = 4'd3;
  localparam logic [3:0] EvQNew     = 4'd4;
  localparam logic [3:0] EvQExist   = 4'd5;
  localparam logic [3:0] EvQFull    = 4'd6;
  localparam logic [3:0] EvSend     = 4'd7;
  localparam logic [3:0] EvUnreach  = 4'd8;
  localparam logic [3:0] EvSweep    = 4'd9;

  localparam logic [0:0] RegEntryTimeout = 1'b0;
  localparam logic [0:0] RegRetryLimit   = 1'b1;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] ip_addr;
    logic [47:0] mac_addr;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  event_res;
    logic [31:0] ip_out;
    logic [47:0] mac_out;
    logic        was_pending;
    logic        last;
  } out_word_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;       // capture input word
    logic tick_inc;   // advance seconds
    logic cache_step; // process cache entry at index
    logic req_step;   // process request slot at index
    logic commit;     // apply insert/queue result
    logic clr_idx;
  } arpc_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic cache_done;
    logic req_done;
    logic req_emit;   // current slot produces a word
  } arpc_sts_t;

endpackage

@@ rtl/core/arpc_datapath.sv @@
// ----------------------------------------------------------------------------
// arpc_datapath
// Tables, scan index and results; one entry or slot per cycle unless stalled.
// ----------------------------------------------------------------------------
module arpc_datapath import arpc_pkg::*; #(
  parameter int unsigned CacheEntries = CacheEntriesDef,
  parameter int unsigned RequestSlots = RequestSlotsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  arpc_cmd_t  cmd_i,
  input  in_word_t   in_i,
  input  logic [15:0] entry_timeout_i,
  input  logic [7:0]  retry_limit_i,
  output arpc_sts_t  sts_o,
  output out_word_t  res_o
);

  localparam int unsigned CW = (CacheEntries > 1) ? $clog2(CacheEntries) : 1;
  localparam int unsigned RW = (RequestSlots > 1) ? $clog2(RequestSlots) : 1;
  localparam int unsigned IW = (CW > RW) ? CW + 1 : RW + 1;

  logic [CacheEntries-1:0] ent_valid_q;
  logic [31:0] ent_ip_q    [CacheEntries];
  logic [47:0] ent_mac_q   [CacheEntries];
  logic [15:0] ent_added_q [CacheEntries];
  logic [RequestSlots-1:0] req_valid_q;
  logic [31:0] req_ip_q    [RequestSlots];
  logic        req_never_q [RequestSlots];
  logic [15:0] req_last_q  [RequestSlots];
  logic [7:0]  req_cnt_q   [RequestSlots];

  logic [15:0] now_q;
  logic [IW-1:0] idx_q;
  in_word_t    cur_q;
  logic        hit_q, pend_q, cfree_q, rfree_q, rexist_q;
  logic [47:0] hmac_q;
  logic [CW-1:0] cslot_q;
  logic [RW-1:0] rslot_q;

  logic [CW-1:0] ci;
  logic [RW-1:0] ri;
  logic cmatch, rmatch, rdue, rgive;
  assign ci = idx_q[CW-1:0];
  assign ri = idx_q[RW-1:0];
  assign cmatch = ent_valid_q[ci] && (ent_ip_q[ci] == cur_q.ip_addr);
  assign rmatch = req_valid_q[ri] && (req_ip_q[ri] == cur_q.ip_addr);
  assign rdue   = req_valid_q[ri] &&
                  (req_never_q[ri] || ((now_q - req_last_q[ri]) > RetryInterval));
  assign rgive  = req_cnt_q[ri] >= retry_limit_i;

  assign sts_o.cache_done = idx_q == IW'(CacheEntries - 1);
  assign sts_o.req_done   = idx_q == IW'(RequestSlots - 1);
  assign sts_o.req_emit   = rdue;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_valid_q <= '0;
      req_valid_q <= '0;
      now_q <= '0;
      idx_q <= '0;
    end else begin
      if (cmd_i.clr_idx) idx_q <= '0;
      else if (cmd_i.cache_step || cmd_i.req_step) idx_q <= idx_q + IW'(1);
      if (cmd_i.tick_inc) now_q <= now_q + 16'd1;
      if (cmd_i.cache_step && cur_q.action == ActTick &&
          (now_q - ent_added_q[ci]) > entry_timeout_i) ent_valid_q[ci] <= 1'b0;
      if (cmd_i.req_step) begin
        if (cur_q.action == ActTick) begin
          if (rdue && rgive) req_valid_q[ri] <= 1'b0;
        end else if (cur_q.action == ActInsert) begin
          if (rmatch && !pend_q) req_valid_q[ri] <= 1'b0;
        end
      end
      if (cmd_i.commit) begin
        if (cur_q.action == ActInsert && cfree_q) ent_valid_q[cslot_q] <= 1'b1;
        if (cur_q.action == ActQueue && !rexist_q && rfree_q)
          req_valid_q[rslot_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cur_q <= in_i;
      hit_q <= 1'b0; pend_q <= 1'b0; cfree_q <= 1'b0;
      rfree_q <= 1'b0; rexist_q <= 1'b0;
    end
    if (cmd_i.cache_step) begin
      if (cmatch) begin
        hit_q <= 1'b1;
        hmac_q <= ent_mac_q[ci];
      end
      if (!ent_valid_q[ci] && !cfree_q) begin
        cfree_q <= 1'b1;
        cslot_q <= ci;
      end
    end
    if (cmd_i.req_step) begin
      if (rmatch) begin
        pend_q <= 1'b1;
        rexist_q <= 1'b1;
      end
      if (!req_valid_q[ri] && !rfree_q) begin
        rfree_q <= 1'b1;
        rslot_q <= ri;
      end
      if (cur_q.action == ActTick && rdue && !rgive) begin
        req_never_q[ri] <= 1'b0;
        req_last_q[ri] <= now_q;
        if (req_cnt_q[ri] != 8'hFF) req_cnt_q[ri] <= req_cnt_q[ri] + 8'd1;
      end
    end
    if (cmd_i.commit) begin
      if (cur_q.action == ActInsert && cfree_q) begin
        ent_ip_q[cslot_q] <= cur_q.ip_addr;
        ent_mac_q[cslot_q] <= cur_q.mac_addr;
        ent_added_q[cslot_q] <= now_q;
      end
      if (cur_q.action == ActQueue && !rexist_q && rfree_q) begin
        req_ip_q[rslot_q] <= cur_q.ip_addr;
        req_never_q[rslot_q] <= 1'b1;
        req_last_q[rslot_q] <= '0;
        req_cnt_q[rslot_q] <= '0;
      end
    end
  end

  // Result word: per-slot tick event while scanning, else the final word.
  always_comb begin
    res_o = '0;
    if (cmd_i.req_step && cur_q.action == ActTick) begin
      res_o.event_res = rgive ? EvUnreach : EvSend;
      res_o.ip_out = req_ip_q[ri];
    end else begin
      res_o.last = 1'b1;
      res_o.ip_out = cur_q.ip_addr;
      unique case (cur_q.action)
        ActTick: begin
          res_o.event_res = EvSweep;
          res_o.ip_out = '0;
        end
        ActLookup: begin
          res_o.event_res = hit_q ? EvHit : EvMiss;
          res_o.mac_out = hit_q ? hmac_q : '0;
        end
        ActInsert: begin
          res_o.event_res = cfree_q ? EvInserted : EvDropped;
          res_o.was_pending = pend_q;
        end
        ActQueue: res_o.event_res = rexist_q ? EvQExist : (rfree_q ? EvQNew : EvQFull);
        default: res_o.event_res = EvMiss;
      endcase
    end
  end

endmodule

@@ rtl/core/arpc_ctrl.sv @@
// ----------------------------------------------------------------------------
// arpc_ctrl
// Sequencer: accept a word, scan tables, present results through a register.
// ----------------------------------------------------------------------------
module arpc_ctrl import arpc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic [1:0] action_i,
  input  logic [1:0] cur_action_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  arpc_sts_t sts_i,
  input  out_word_t res_i,
  output out_word_t out_o,
  output arpc_cmd_t cmd_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StCache = 3'd1;
  localparam logic [2:0] StReq   = 3'd2;
  localparam logic [2:0] StFinal = 3'd3;
  localparam logic [2:0] StWait  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       ov_q;
  out_word_t  out_q;
  logic       free;

  assign free = !ov_q || out_ready_i;
  assign in_ready_o = (state_q == StIdle);
  assign out_valid_o = ov_q;
  assign out_o = out_q;

  always_comb begin
    cmd_o = '0;
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_valid_i) begin
        cmd_o.load = 1'b1;
        cmd_o.clr_idx = 1'b1;
        cmd_o.tick_inc = (action_i == ActTick);
        state_d = (action_i == ActQueue) ? StReq : StCache;
      end
      StCache: begin
        cmd_o.cache_step = 1'b1;
        if (sts_i.cache_done) begin
          cmd_o.clr_idx = 1'b1;
          state_d = (cur_action_i == ActLookup) ? StFinal : StReq;
        end
      end
      StReq: begin
        // hold the slot while a tick result cannot be registered
        if (!(cur_action_i == ActTick && sts_i.req_emit && !free)) begin
          cmd_o.req_step = 1'b1;
          if (sts_i.req_done) begin
            cmd_o.clr_idx = 1'b1;
            state_d = StFinal;
          end
        end
      end
      StFinal: if (free) begin
        cmd_o.commit = 1'b1;
        state_d = StWait;
      end
      StWait: if (!ov_q || out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  logic load_out;
  assign load_out = (cmd_o.req_step && cur_action_i == ActTick && sts_i.req_emit)
                    || cmd_o.commit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) out_q <= res_i;
  end

endmodule

@@ rtl/core/arp_cache_with_request_retry_unit.sv @@
// ----------------------------------------------------------------------------
// arp_cache_with_request_retry_unit
// ARP cache with pending-request table and retry timer.
// ----------------------------------------------------------------------------
// Usage: one input word per action (tick, lookup, insert, queue) on the
// valid/ready input channel; result words leave on the output channel, the
// final one of each action flagged by last. A tick yields one word per due
// request slot plus a sweep-done word; other actions yield one word.
// Processing: capture the word, scan the cache entries, scan the request
// slots, then commit; a lookup skips the request scan and a queue skips the
// cache scan. One word is processed at a time, and each table is scanned
// sequentially, one entry or slot per step.
// Results go through one output register; while the receiver stalls the
// scan holds at the slot whose word cannot be registered yet.
// Reset clears all valid bits, the seconds counter, and loads the register
// defaults (entry_timeout 15, retry_limit 5). Configuration goes through the
// APB port, written by the user only while the block is idle (not enforced).
// ----------------------------------------------------------------------------
`include "arp_cache_with_request_retry_unit_macros.svh"

module arp_cache_with_request_retry_unit import arpc_pkg::*; #(
  parameter int unsigned CacheEntries = CacheEntriesDef,
  parameter int unsigned RequestSlots = RequestSlotsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_word_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_word_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:2]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] entry_timeout_q;
  logic [7:0]  retry_limit_q;
  arpc_cmd_t   cmd;
  arpc_sts_t   sts;
  out_word_t   res;
  logic [1:0]  cur_action;
  in_word_t    cur_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_timeout_q <= EntryTimeoutRst;
      retry_limit_q <= RetryLimitRst;
    end else if (psel && penable && pwrite) begin
      unique case (paddr)
        RegEntryTimeout: entry_timeout_q <= pwdata[15:0];
        RegRetryLimit:   retry_limit_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      RegEntryTimeout: prdata = {16'd0, entry_timeout_q};
      RegRetryLimit:   prdata = {24'd0, retry_limit_q};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd.load) cur_q <= in_data_i;
  end
  assign cur_action = cur_q.action;

  arpc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .action_i(in_data_i.action), .cur_action_i(cur_action),
    .out_valid_o, .out_ready_i, .sts_i(sts), .res_i(res),
    .out_o(out_data_o), .cmd_o(cmd)
  );

  arpc_datapath #(.CacheEntries(CacheEntries), .RequestSlots(RequestSlots)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .in_i(in_data_i),
    .entry_timeout_i(entry_timeout_q), .retry_limit_i(retry_limit_q),
    .sts_o(sts), .res_o(res)
  );

  `ARPC_ASSERT_IMP(a_no_accept_busy, clk_i, rst_ni, in_valid_i && in_ready_o, !out_valid_o, "accept while a word is pending")
  `ARPC_ASSERT_NXT(a_load_out, clk_i, rst_ni, cmd.commit, out_valid_o && out_data_o.last, "commit must present final word")
  `ARPC_ASSERT_IMP(a_steps_excl, clk_i, rst_ni, cmd.cache_step, !cmd.req_step && !cmd.commit, "scan steps overlap")

endmodule

@@ sim/tb_arp_cache_with_request_retry_unit.sv @@
// ----------------------------------------------------------------------------
// tb_arp_cache_with_request_retry_unit
// Self-checking bench for the ARP cache with request retry. Drives lookup,
// insert, queue and tick words with random gaps and output stalls. A local
// model of the cache and request tables predicts each result word, and every
// accepted output word is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_arp_cache_with_request_retry_unit;
  import arpc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumEntries = 16;
  localparam int NumSlots   = 8;
  localparam int CycleLimit = 600000;
  localparam int SettleCyc  = 40;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_word_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_word_t   out_data_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:2]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  arp_cache_with_request_retry_unit dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Model state
  logic [15:0] cfg_timeout;
  logic [7:0]  cfg_retry;
  logic [15:0] now_sec;
  logic        ent_vld [NumEntries];
  logic [31:0] ent_ip  [NumEntries];
  logic [47:0] ent_mac [NumEntries];
  logic [15:0] ent_added [NumEntries];
  logic        req_vld [NumSlots];
  logic [31:0] req_ip  [NumSlots];
  logic        req_fresh [NumSlots];
  logic [15:0] req_sent_at [NumSlots];
  logic [7:0]  req_count [NumSlots];

  out_word_t exp_words[$];
  in_word_t  pending_words[$];
  bit        failed = 1'b0;
  bit        no_idle = 1'b0;
  bit        tx_pause = 1'b0;
  logic      hold_start = 1'b0;
  int        hold_cnt = 0;
  int        tx_gap = 0;
  int        rx_stall = 0;
  int        cycles = 0;
  logic [31:0] ip_pool [12];

  function automatic void push_word(logic [3:0] ev, logic [31:0] ip, logic [47:0] mac,
                                    logic pend, logic lst);
    out_word_t o;
    o.event_res = ev;
    o.ip_out = ip;
    o.mac_out = mac;
    o.was_pending = pend;
    o.last = lst;
    exp_words.push_back(o);
  endfunction

  function automatic void arp_predict(in_word_t w);
    int hit;
    int slot;
    logic pend;
    logic [15:0] age;
    hit = -1;
    slot = -1;
    pend = 1'b0;
    case (w.action)
      ActTick: begin
        now_sec = now_sec + 16'd1;
        for (int i = 0; i < NumEntries; i++) begin
          age = now_sec - ent_added[i];
          if (ent_vld[i] && age > cfg_timeout) ent_vld[i] = 1'b0;
        end
        for (int i = 0; i < NumSlots; i++) begin
          age = now_sec - req_sent_at[i];
          if (!req_vld[i] || (!req_fresh[i] && age <= RetryInterval)) continue;
          if (req_count[i] >= cfg_retry) begin
            push_word(EvUnreach, req_ip[i], '0, 1'b0, 1'b0);
            req_vld[i] = 1'b0;
          end else begin
            push_word(EvSend, req_ip[i], '0, 1'b0, 1'b0);
            req_fresh[i] = 1'b0;
            req_sent_at[i] = now_sec;
            if (req_count[i] != 8'hFF) req_count[i]++;
          end
        end
        push_word(EvSweep, '0, '0, 1'b0, 1'b1);
      end
      ActLookup: begin
        for (int i = 0; i < NumEntries; i++)
          if (ent_vld[i] && ent_ip[i] == w.ip_addr) hit = i;
        if (hit >= 0) push_word(EvHit, w.ip_addr, ent_mac[hit], 1'b0, 1'b1);
        else push_word(EvMiss, w.ip_addr, '0, 1'b0, 1'b1);
      end
      ActInsert: begin
        for (int i = 0; i < NumSlots; i++)
          if (!pend && req_vld[i] && req_ip[i] == w.ip_addr) begin
            req_vld[i] = 1'b0;
            pend = 1'b1;
          end
        for (int i = 0; i < NumEntries; i++)
          if (slot < 0 && !ent_vld[i]) slot = i;
        if (slot >= 0) begin
          ent_vld[slot] = 1'b1;
          ent_ip[slot] = w.ip_addr;
          ent_mac[slot] = w.mac_addr;
          ent_added[slot] = now_sec;
          push_word(EvInserted, w.ip_addr, '0, pend, 1'b1);
        end else begin
          push_word(EvDropped, w.ip_addr, '0, pend, 1'b1);
        end
      end
      default: begin
        for (int i = 0; i < NumSlots; i++) begin
          if (req_vld[i] && req_ip[i] == w.ip_addr) hit = i;
          if (!req_vld[i] && slot < 0) slot = i;
        end
        if (hit >= 0) push_word(EvQExist, w.ip_addr, '0, 1'b0, 1'b1);
        else if (slot < 0) push_word(EvQFull, w.ip_addr, '0, 1'b0, 1'b1);
        else begin
          req_vld[slot] = 1'b1;
          req_ip[slot] = w.ip_addr;
          req_fresh[slot] = 1'b1;
          req_sent_at[slot] = '0;
          req_count[slot] = '0;
          push_word(EvQNew, w.ip_addr, '0, 1'b0, 1'b1);
        end
      end
    endcase
  endfunction

  function automatic int draw_gap();
    return no_idle ? 0 : int'($urandom_range(0, 19));
  endfunction

  // Input driver
  always @(posedge clk_i or negedge rst_ni) begin : drv
    int g;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      tx_gap <= 0;
    end else if (in_valid_i && in_ready_o) begin
      arp_predict(in_data_i);
      g = draw_gap();
      if (g == 0 && pending_words.size() > 0 && !tx_pause) begin
        in_data_i <= pending_words.pop_front();
      end else begin
        in_valid_i <= 1'b0;
        tx_gap <= g;
      end
    end else if (!in_valid_i) begin
      if (tx_gap > 0) begin
        tx_gap <= tx_gap - 1;
      end else if (pending_words.size() > 0 && !tx_pause) begin
        in_valid_i <= 1'b1;
        in_data_i <= pending_words.pop_front();
      end
    end
  end

  // Long receiver hold-off
  always @(posedge clk_i) begin
    if (hold_start) hold_cnt <= 400;
    else if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
  end

  // Output monitor
  always @(posedge clk_i or negedge rst_ni) begin : mon
    int st;
    out_word_t e;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_stall <= 0;
    end else begin
      st = (rx_stall > 0) ? rx_stall - 1 : 0;
      if (out_valid_o && out_ready_i) begin
        st = draw_gap();
        if (exp_words.size() == 0) begin
          $error("unexpected word: event_res %0d ip_out %h", out_data_o.event_res,
                 out_data_o.ip_out);
          failed = 1'b1;
        end else begin
          e = exp_words.pop_front();
          if (e.event_res !== out_data_o.event_res) begin
            $error("event_res: expected %0d, got %0d", e.event_res, out_data_o.event_res);
            failed = 1'b1;
          end
          if (e.ip_out !== out_data_o.ip_out) begin
            $error("ip_out: expected %h, got %h", e.ip_out, out_data_o.ip_out);
            failed = 1'b1;
          end
          if (e.mac_out !== out_data_o.mac_out) begin
            $error("mac_out: expected %h, got %h", e.mac_out, out_data_o.mac_out);
            failed = 1'b1;
          end
          if (e.was_pending !== out_data_o.was_pending) begin
            $error("was_pending: expected %b, got %b", e.was_pending,
                   out_data_o.was_pending);
            failed = 1'b1;
          end
          if (e.last !== out_data_o.last) begin
            $error("last: expected %b, got %b", e.last, out_data_o.last);
            failed = 1'b1;
          end
        end
      end
      rx_stall <= st;
      out_ready_i <= (st == 0) && (hold_cnt == 0) && !hold_start;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic in_word_t mk_word(logic [1:0] act, logic [31:0] ip, logic [47:0] mac);
    in_word_t w;
    w.action = act;
    w.ip_addr = ip;
    w.mac_addr = mac;
    return w;
  endfunction

  function automatic in_word_t rand_word();
    int r;
    logic [63:0] m;
    logic [1:0] act;
    logic [31:0] ip;
    r = $urandom_range(0, 99);
    m = {$urandom, $urandom};
    act = (r < 30) ? ActTick : (r < 55) ? ActLookup : (r < 78) ? ActInsert : ActQueue;
    ip = ($urandom_range(0, 7) == 0) ? $urandom : ip_pool[$urandom_range(0, 11)];
    return mk_word(act, ip, m[47:0]);
  endfunction

  task automatic drain();
    wait (pending_words.size() == 0 && !in_valid_i && exp_words.size() == 0);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [0:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= idx;
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == RegEntryTimeout) cfg_timeout = val[15:0];
    else cfg_retry = val[7:0];
  endtask

  task automatic run_phase(logic [15:0] tmo, logic [7:0] rty, int n);
    drain();
    reg_write(RegEntryTimeout, {16'h0, tmo});
    reg_write(RegRetryLimit, {24'h0, rty});
    repeat (n) pending_words.push_back(rand_word());
  endtask

  initial begin
    cfg_timeout = EntryTimeoutRst;
    cfg_retry = RetryLimitRst;
    now_sec = '0;
    for (int i = 0; i < NumEntries; i++) begin
      ent_vld[i] = 1'b0; ent_ip[i] = '0; ent_mac[i] = '0; ent_added[i] = '0;
    end
    for (int i = 0; i < NumSlots; i++) begin
      req_vld[i] = 1'b0; req_ip[i] = '0; req_fresh[i] = 1'b0;
      req_sent_at[i] = '0; req_count[i] = '0;
    end
    ip_pool[0] = 32'h0;
    ip_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 12; i++) ip_pool[i] = 32'h0A00_0000 + i;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, duplicates, pending removal, full request table
    pending_words.push_back(mk_word(ActLookup, 32'h0, '0));
    pending_words.push_back(mk_word(ActInsert, 32'h0, 48'h0));
    pending_words.push_back(mk_word(ActInsert, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF));
    pending_words.push_back(mk_word(ActLookup, 32'hFFFF_FFFF, '0));
    pending_words.push_back(mk_word(ActInsert, 32'hFFFF_FFFF, 48'h1234_5678_9ABC));
    pending_words.push_back(mk_word(ActLookup, 32'hFFFF_FFFF, '1));
    pending_words.push_back(mk_word(ActLookup, 32'h0, '0));
    for (int i = 0; i < 9; i++)
      pending_words.push_back(mk_word(ActQueue, 32'hC0A8_0000 + i, '0));
    pending_words.push_back(mk_word(ActQueue, 32'hC0A8_0001, '0));
    for (int i = 0; i < 3; i++) pending_words.push_back(mk_word(ActTick, '1, '1));
    pending_words.push_back(mk_word(ActInsert, 32'hC0A8_0002, 48'hA5A5_5A5A_0F0F));
    pending_words.push_back(mk_word(ActLookup, 32'hC0A8_0002, '0));
    pending_words.push_back(mk_word(ActTick, '0, '0));

    // Stall the receiver so the block backs up against its input
    @(posedge clk_i);
    hold_start <= 1'b1;
    @(posedge clk_i);
    hold_start <= 1'b0;

    run_phase(16'd15, 8'd5, 45);
    run_phase(16'd0, 8'd1, 30);
    run_phase(16'hFFFF, 8'hFF, 35);
    no_idle = 1'b1;
    run_phase(16'd3, 8'd2, 30);
    drain();
    no_idle = 1'b0;
    run_phase(16'd1, 8'd0, 25);

    // Pause the sender until all results are back, then resume
    wait (pending_words.size() == 10);
    tx_pause = 1'b1;
    wait (!in_valid_i && exp_words.size() == 0);
    tx_pause = 1'b0;
    drain();

    if (!failed && exp_words.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
